FILE: sv/dsh_pkg.sv
package dsh_pkg;

    localparam int ANG_W = 32;
    localparam int MUL_W = 34;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic signed [ANG_W-1:0] INIT_ANGLE_RST = 32'sd421658414;
    localparam logic [29:0] TURN_SCALE = 30'd683565276;
    localparam logic [30:0] Q30_ONE = 31'd1073741824;
    localparam logic signed [31:0] POLY_START = -32'sd3864;
    localparam logic signed [31:0] POLY_C [5] = '{
        32'sd172272, -32'sd5026995, 32'sd85569306, -32'sd693598668, 32'sd1686629713
    };

    typedef enum logic [2:0] {
        CFG_GAIN_K     = 3'd0,
        CFG_STEP_DT    = 3'd1,
        CFG_NOISE      = 3'd2,
        CFG_DLY_WHOLE  = 3'd3,
        CFG_DLY_FRAC   = 3'd4,
        CFG_INIT_ANGLE = 3'd5
    } t_cfg_idx;

    typedef logic signed [MUL_W-1:0] t_mul_op;
    typedef logic signed [PROD_W-1:0] t_prod;

endpackage

FILE: sv/dsh_ram.sv
module dsh_ram
    import dsh_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/dsh_mul.sv
module dsh_mul
    import dsh_pkg::*;
(
    input  logic    i_clk,
    input  t_mul_op i_a,
    input  t_mul_op i_b,
    output t_prod   o_prod
);

    t_prod r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

FILE: sv/delay_sde_heun_step.sv
// Channel  | Direction | Handshake                        | Beat
// input    | in        | i_in_valid / o_in_stall          | i_noise_sample, i_restart
// output   | out       | o_out_valid / i_out_stall        | o_angle, o_step_index
// config   | in        | i_cfg_valid / o_cfg_ready        | i_cfg_index, i_cfg_data
// An item makes two passes through the shared registered multiplier; the length of each pass
// is set by whether the delayed angle is the initial angle, one history entry or an
// interpolation.
// After reset the S_INIT state writes the first history slot before the first beat is taken.
// The input is stalled until the result of the current beat is in the output register.
// A stalled output holds its beat; the next input beat is accepted meanwhile, and its result
// waits until the output register is free.
module delay_sde_heun_step
    import dsh_pkg::*;
#(
    parameter int HIST_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_noise_sample,
    input  logic               i_restart,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_angle,
    output logic [31:0]        o_step_index,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int AW = $clog2(HIST_DEPTH);
    localparam int FW = $clog2(HIST_DEPTH + 1);
    localparam int LW = ((AW > 8) ? AW : 8) + 2;
    localparam logic [LW-1:0] W_MAX = LW'(HIST_DEPTH - 2);

    typedef enum logic [19:0] {
        S_INIT  = 20'h00001, S_IDLE  = 20'h00002, S_START = 20'h00004, S_NOISE = 20'h00008,
        S_D0    = 20'h00010, S_D1    = 20'h00020, S_D2    = 20'h00040, S_D3    = 20'h00080,
        S_SIN0  = 20'h00100, S_SIN1  = 20'h00200, S_SIN2  = 20'h00400, S_PMUL  = 20'h00800,
        S_PADD  = 20'h01000, S_SFIN0 = 20'h02000, S_SFIN1 = 20'h04000, S_SLP0  = 20'h08000,
        S_SLP1  = 20'h10000, S_AVG   = 20'h20000, S_STEP  = 20'h40000, S_DONE  = 20'h80000
    } t_state;

    t_state r_state;

    logic signed [15:0] r_gain;
    logic [15:0]        r_dt, r_nscale, r_frac;
    logic [7:0]         r_dw;
    logic signed [31:0] r_init;

    logic signed [15:0] r_ns;
    logic               r_rst;
    logic signed [32:0] r_noise;
    logic               r_phase;
    logic signed [31:0] r_cur, r_pred, r_dly, r_v1, r_v2, r_sin, r_p;
    logic [AW-1:0]      r_head, r_l1;
    logic [FW-1:0]      r_fill;
    logic [31:0]        r_count;
    logic [1:0]         r_q;
    logic [30:0]        r_u, r_u2;
    logic [2:0]         r_ci;
    logic signed [33:0] r_slope, r_s1;

    logic               r_ov;
    logic signed [31:0] r_oangle;
    logic [31:0]        r_ocount;

    t_mul_op mul_a, mul_b;
    t_prod   prod;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr, head_nxt;
    logic [ANG_W-1:0]     ram_wdata, ram_rdata;

    logic [LW-1:0]        w_eff, l1_c;
    logic                 early;
    logic [31:0]          ph;
    logic [30:0]          u_c;
    logic signed [37:0]   s_c;
    logic signed [31:0]   sin_c;
    logic signed [PROD_W-1:0] neg_prod, step_x;
    logic signed [51:0]   step_sh;
    logic signed [31:0]   step_y, step_z;
    logic signed [32:0]   sat_sum;
    logic signed [34:0]   slope_sum;
    logic signed [33:0]   avg_c, interp_sum;
    logic signed [32:0]   diff_c;
    logic [16:0]          alpha;
    logic                 out_free;

    function automatic logic [AW-1:0] ring_idx(input logic [AW-1:0] head,
                                               input logic [AW-1:0] lag);
        logic [AW:0] t;
        t = {1'b0, head} - {1'b0, lag};
        if (head < lag) begin
            t = t + (AW+1)'(HIST_DEPTH);
        end
        return t[AW-1:0];
    endfunction

    dsh_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    dsh_ram #(.WIDTH(ANG_W), .DEPTH(HIST_DEPTH)) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        w_eff = (LW'(r_dw) > W_MAX) ? W_MAX : LW'(r_dw);
        early = (LW'(r_fill) + LW'(r_phase)) <= w_eff;
        l1_c = w_eff + LW'(1) - LW'(r_phase);
        head_nxt = (r_head == AW'(HIST_DEPTH - 1)) ? '0 : r_head + AW'(1);
        ram_raddr = (r_state == S_D0) ? ring_idx(r_head, AW'(l1_c) - AW'(1))
                                      : ring_idx(r_head, r_l1);

        ph = prod[59:28];
        u_c = ph[30] ? (Q30_ONE - {1'b0, ph[29:0]}) : {1'b0, ph[29:0]};
        s_c = prod[67:30];
        if (s_c < 0) begin
            sin_c = '0;
        end else if (s_c > 38'sd1073741824) begin
            sin_c = 32'sd1073741824;
        end else begin
            sin_c = s_c[31:0];
        end
        if (r_q[1]) begin
            sin_c = -sin_c;
        end

        neg_prod = -prod;
        slope_sum = 35'(r_s1) + 35'(r_slope);
        avg_c = r_phase ? slope_sum[34:1] : r_slope;
        diff_c = 33'(r_v2) - 33'($signed(ram_rdata));
        alpha = 17'd65536 - 17'(r_frac);
        interp_sum = 34'(r_v1) + prod[49:16];

        step_x = prod + {{(PROD_W-49){r_noise[32]}}, r_noise, 16'b0};
        step_sh = step_x[67:16];
        if (step_sh > 52'sd2147483647) begin
            step_y = 32'sh7fffffff;
        end else if (step_sh < -52'sd2147483648) begin
            step_y = 32'sh80000000;
        end else begin
            step_y = step_sh[31:0];
        end
        sat_sum = 33'(r_cur) + 33'(step_y);
        if (sat_sum > 33'sd2147483647) begin
            step_z = 32'sh7fffffff;
        end else if (sat_sum < -33'sd2147483648) begin
            step_z = 32'sh80000000;
        end else begin
            step_z = sat_sum[31:0];
        end

        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_START: begin
                mul_a = MUL_W'(r_ns);
                mul_b = $signed({{(MUL_W-16){1'b0}}, r_nscale});
            end
            S_D2: begin
                mul_a = $signed({{(MUL_W-17){1'b0}}, alpha});
                mul_b = MUL_W'(diff_c);
            end
            S_SIN0: begin
                mul_a = MUL_W'(r_dly);
                mul_b = $signed({{(MUL_W-30){1'b0}}, TURN_SCALE});
            end
            S_SIN1: begin
                mul_a = $signed({{(MUL_W-31){1'b0}}, u_c});
                mul_b = $signed({{(MUL_W-31){1'b0}}, u_c});
            end
            S_PMUL: begin
                mul_a = MUL_W'(r_p);
                mul_b = $signed({{(MUL_W-31){1'b0}}, r_u2});
            end
            S_SFIN0: begin
                mul_a = MUL_W'(r_p);
                mul_b = $signed({{(MUL_W-31){1'b0}}, r_u});
            end
            S_SLP0: begin
                mul_a = MUL_W'(r_gain);
                mul_b = MUL_W'(r_sin);
            end
            S_AVG: begin
                mul_a = avg_c;
                mul_b = $signed({{(MUL_W-16){1'b0}}, r_dt});
            end
            default: begin
            end
        endcase

        ram_we = (r_state == S_INIT) || (r_state == S_START && r_rst) ||
                 (r_state == S_STEP && r_phase);
        ram_waddr = (r_state == S_STEP) ? head_nxt : '0;
        ram_wdata = (r_state == S_INIT) ? INIT_ANGLE_RST :
                    (r_state == S_START) ? r_init : step_z;
        out_free = !r_ov || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= 16'sd328;
            r_dt <= 16'd6554;
            r_nscale <= 16'd2072;
            r_dw <= 8'd200;
            r_frac <= '0;
            r_init <= INIT_ANGLE_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN_K:     r_gain <= i_cfg_data[15:0];
                CFG_STEP_DT:    r_dt <= i_cfg_data[15:0];
                CFG_NOISE:      r_nscale <= i_cfg_data[15:0];
                CFG_DLY_WHOLE:  r_dw <= i_cfg_data[7:0];
                CFG_DLY_FRAC:   r_frac <= i_cfg_data[15:0];
                CFG_INIT_ANGLE: r_init <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cur <= INIT_ANGLE_RST;
            r_head <= '0;
            r_fill <= '0;
            r_count <= '0;
            r_phase <= 1'b0;
            r_ci <= '0;
            r_ov <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_INIT: r_state <= S_IDLE;
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_ns <= i_noise_sample;
                        r_rst <= i_restart;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    if (r_rst) begin
                        r_cur <= r_init;
                        r_head <= '0;
                        r_fill <= '0;
                        r_count <= '0;
                    end
                    r_state <= S_NOISE;
                end
                S_NOISE: begin
                    r_noise <= prod[32:0];
                    r_phase <= 1'b0;
                    r_state <= S_D0;
                end
                S_D0: begin
                    r_l1 <= AW'(l1_c);
                    if (early) begin
                        r_dly <= r_init;
                        r_state <= S_SIN0;
                    end else begin
                        r_state <= S_D1;
                    end
                end
                S_D1: begin
                    if (r_frac == '0) begin
                        r_dly <= (r_l1 == '0) ? r_pred : $signed(ram_rdata);
                        r_state <= S_SIN0;
                    end else begin
                        r_v2 <= (r_l1 == '0) ? r_pred : $signed(ram_rdata);
                        r_state <= S_D2;
                    end
                end
                S_D2: begin
                    r_v1 <= $signed(ram_rdata);
                    r_state <= S_D3;
                end
                S_D3: begin
                    r_dly <= interp_sum[31:0];
                    r_state <= S_SIN0;
                end
                S_SIN0: r_state <= S_SIN1;
                S_SIN1: begin
                    r_q <= ph[31:30];
                    r_u <= u_c;
                    r_state <= S_SIN2;
                end
                S_SIN2: begin
                    r_u2 <= prod[60:30];
                    r_p <= POLY_START;
                    r_ci <= '0;
                    r_state <= S_PMUL;
                end
                S_PMUL: r_state <= S_PADD;
                S_PADD: begin
                    r_p <= prod[61:30] + POLY_C[r_ci];
                    if (r_ci == 3'd4) begin
                        r_state <= S_SFIN0;
                    end else begin
                        r_ci <= r_ci + 3'd1;
                        r_state <= S_PMUL;
                    end
                end
                S_SFIN0: r_state <= S_SFIN1;
                S_SFIN1: begin
                    r_sin <= sin_c;
                    r_state <= S_SLP0;
                end
                S_SLP0: r_state <= S_SLP1;
                S_SLP1: begin
                    r_slope <= neg_prod[47:14];
                    if (!r_phase) begin
                        r_s1 <= neg_prod[47:14];
                    end
                    r_state <= S_AVG;
                end
                S_AVG: r_state <= S_STEP;
                S_STEP: begin
                    if (!r_phase) begin
                        r_pred <= step_z;
                        r_phase <= 1'b1;
                        r_state <= S_D0;
                    end else begin
                        r_cur <= step_z;
                        r_head <= head_nxt;
                        if (r_fill != FW'(HIST_DEPTH)) begin
                            r_fill <= r_fill + FW'(1);
                        end
                        r_count <= r_count + 32'd1;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_oangle <= r_cur;
                        r_ocount <= r_count;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_INIT;
            endcase
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_angle = r_oangle;
    assign o_step_index = r_ocount;
    assign o_cfg_ready = 1'b1;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_START))
        else $error("accepted beat did not start a step");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(HIST_DEPTH))
        else $error("fill count beyond history depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_head} < (AW+1)'(HIST_DEPTH))
        else $error("ring head beyond history depth");

    a_done_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (o_out_valid && r_state == S_IDLE))
        else $error("finished step not presented");

endmodule

FILE: verif/delay_sde_heun_step_tb.sv
module delay_sde_heun_step_tb
    import dsh_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 256;
    localparam int BUF_DEPTH = 4096;
    localparam longint A_MAX = 64'sd2147483647;
    localparam longint A_MIN = -64'sd2147483648;
    localparam longint ONE_Q30 = 64'sd1073741824;

    typedef struct {
        logic signed [15:0] noise;
        logic               restart;
    } t_step_item;

    typedef struct {
        logic signed [31:0] angle;
        logic [31:0]        index;
    } t_step_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [15:0] i_noise_sample;
    logic               i_restart;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [31:0] o_angle;
    logic [31:0]        o_step_index;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;

    delay_sde_heun_step i_dut (.*);

    t_step_item   pend_buf[BUF_DEPTH];
    t_step_result exp_buf[BUF_DEPTH];
    int           pend_wr = 0;
    int           pend_rd = 0;
    int           exp_wr = 0;
    int           exp_rd = 0;
    int           error_count = 0;
    bit           send_calm = 0;
    bit           recv_calm = 0;
    bit           hold_req = 0;
    bit           hold_taken;
    int           hold_cnt;
    int           gap_left;
    int           stall_left;

    logic signed [15:0] m_gain;
    logic [15:0]        m_dt;
    logic [15:0]        m_noise_scale;
    logic [7:0]         m_whole;
    logic [15:0]        m_frac;
    logic [31:0]        m_init;
    longint             m_history[DEPTH];
    longint             m_angle;
    logic [31:0]        m_count;
    int                 m_head;
    int                 m_fill;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("delay_sde_heun_step_tb NOT OK");
        $finish;
    end

    task automatic report(input string what, input longint got, input longint want);
        error_count++;
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    function automatic void add_pending(input t_step_item it);
        pend_buf[pend_wr % BUF_DEPTH] = it;
        pend_wr++;
    endfunction

    function automatic longint sat_add(input longint a, input longint b);
        longint s;
        s = a + b;
        if (s > A_MAX) return A_MAX;
        if (s < A_MIN) return A_MIN;
        return s;
    endfunction

    function automatic longint q44_to_angle(input longint x);
        longint s;
        s = x >>> 16;
        if (s > A_MAX) return A_MAX;
        if (s < A_MIN) return A_MIN;
        return s;
    endfunction

    function automatic longint sine_q30(input longint a);
        longint unsigned prod;
        logic [31:0]     ph;
        longint          u, u2, p, s;
        prod = longint'(a) * 64'd683565276;
        ph = prod[59:28];
        u = ph[0 +: 30];
        if (ph[30]) u = ONE_Q30 - u;
        u2 = (u * u) >>> 30;
        p = -64'sd3864;
        p = ((p * u2) >>> 30) + 64'sd172272;
        p = ((p * u2) >>> 30) - 64'sd5026995;
        p = ((p * u2) >>> 30) + 64'sd85569306;
        p = ((p * u2) >>> 30) - 64'sd693598668;
        p = ((p * u2) >>> 30) + 64'sd1686629713;
        s = (p * u) >>> 30;
        if (s < 0) s = 0;
        if (s > ONE_Q30) s = ONE_Q30;
        return ph[31] ? -s : s;
    endfunction

    function automatic longint ring_value(input int lag, input longint pred);
        if (lag < 0) return pred;
        return m_history[(m_head + DEPTH - lag) % DEPTH];
    endfunction

    function automatic longint delayed_angle(input int ahead, input longint pred);
        int     w;
        longint v1, v2;
        w = (m_whole > DEPTH - 2) ? DEPTH - 2 : int'(m_whole);
        if (m_fill + ahead <= w) return longint'($signed(m_init));
        v2 = ring_value(w - ahead, pred);
        if (m_frac == 0) return v2;
        v1 = ring_value(w - ahead + 1, pred);
        return v1 + (((64'sd65536 - longint'(m_frac)) * (v2 - v1)) >>> 16);
    endfunction

    function automatic void restart_angle();
        m_angle = longint'($signed(m_init));
        m_count = 0;
        m_head = 0;
        m_fill = 0;
        m_history[0] = m_angle;
    endfunction

    function automatic t_step_result heun_step(input t_step_item it);
        t_step_result r;
        longint       g, dt, noise, slope1, slope2, pred;
        if (it.restart) restart_angle();
        g = longint'(m_gain);
        dt = longint'(m_dt);
        noise = longint'(it.noise) * longint'(m_noise_scale) * 64'sd65536;
        slope1 = (-g * sine_q30(delayed_angle(0, 0))) >>> 14;
        pred = sat_add(m_angle, q44_to_angle(slope1 * dt + noise));
        slope2 = (-g * sine_q30(delayed_angle(1, pred))) >>> 14;
        m_angle = sat_add(m_angle, q44_to_angle(((slope1 + slope2) >>> 1) * dt + noise));
        m_head = (m_head + 1) % DEPTH;
        m_history[m_head] = m_angle;
        if (m_fill < DEPTH) m_fill++;
        m_count++;
        r.angle = m_angle[31:0];
        r.index = m_count;
        return r;
    endfunction

    function automatic int draw_wait(input bit calm);
        if (calm) return 0;
        return $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
    endfunction

    always @(posedge i_clk) begin
        t_step_item it;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_noise_sample <= '0;
            i_restart <= 1'b0;
            gap_left <= 0;
        end else if (i_in_valid && !o_in_stall) begin
            it.noise = i_noise_sample;
            it.restart = i_restart;
            exp_buf[exp_wr % BUF_DEPTH] = heun_step(it);
            exp_wr++;
            gap_left <= draw_wait(send_calm);
            i_in_valid <= 1'b0;
        end else if (!i_in_valid) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (pend_wr != pend_rd) begin
                it = pend_buf[pend_rd % BUF_DEPTH];
                pend_rd++;
                i_noise_sample <= it.noise;
                i_restart <= it.restart;
                i_in_valid <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_step_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left <= 0;
            hold_cnt <= 0;
            hold_taken <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (exp_wr == exp_rd) begin
                    report("unexpected beat", o_step_index, -1);
                end else begin
                    want = exp_buf[exp_rd % BUF_DEPTH];
                    exp_rd++;
                    if (o_angle !== want.angle) report("angle", o_angle, want.angle);
                    if (o_step_index !== want.index)
                        report("step_index", o_step_index, want.index);
                end
                stall_left <= draw_wait(recv_calm);
            end
            if (hold_req && !hold_taken) begin
                hold_taken <= 1'b1;
                hold_cnt <= 400;
                i_out_stall <= 1'b1;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0 && !(o_out_valid && !i_out_stall)) begin
                stall_left <= stall_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= o_out_valid && !i_out_stall ? 1'b1 : 1'b0;
            end
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_GAIN_K:     m_gain = data[15:0];
            CFG_STEP_DT:    m_dt = data[15:0];
            CFG_NOISE:      m_noise_scale = data[15:0];
            CFG_DLY_WHOLE:  m_whole = data[7:0];
            CFG_DLY_FRAC:   m_frac = data[15:0];
            CFG_INIT_ANGLE: m_init = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pend_wr != pend_rd || i_in_valid || exp_wr != exp_rd)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick16(input logic [15:0] lo, input logic [15:0] hi);
        case ($urandom_range(0, 5))
            0: return lo;
            1: return hi;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_random(input int count);
        t_step_item it;
        repeat (count) begin
            it.noise = $urandom_range(0, 3) == 0 ? 16'($urandom)
                                                 : 16'($signed($urandom_range(0, 16384)) - 8192);
            it.restart = $urandom_range(0, 60) == 0;
            add_pending(it);
        end
    endtask

    initial begin
        t_step_item it;
        logic [7:0] w;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_GAIN_K;
        i_cfg_data = '0;
        m_gain = 16'sd328;
        m_dt = 16'd6554;
        m_noise_scale = 16'd2072;
        m_whole = 8'd200;
        m_frac = 16'd0;
        m_init = 32'd421658414;
        foreach (m_history[k]) m_history[k] = 0;
        restart_angle();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (m_history[k]) begin
            if (k >= 6) break;
            it.noise = (k == 0) ? -16'sd32768 : (k == 1) ? 16'sd32767 : 16'sd0;
            it.restart = (k == 3);
            add_pending(it);
        end
        wait_drained();

        write_reg(CFG_DLY_WHOLE, 0);
        write_reg(CFG_DLY_FRAC, 0);
        write_reg(CFG_GAIN_K, 32'h7FFF);
        write_reg(CFG_STEP_DT, 32'hFFFF);
        write_reg(CFG_NOISE, 32'hFFFF);
        write_reg(CFG_INIT_ANGLE, 32'h7FFF_FFFF);
        it.restart = 1;
        it.noise = 16'sd32767;
        add_pending(it);
        it.restart = 0;
        add_pending(it);
        it.noise = -16'sd32768;
        add_pending(it);
        wait_drained();
        write_reg(CFG_DLY_FRAC, 32'hFFFF);
        write_reg(CFG_GAIN_K, 32'h8000);
        write_reg(CFG_INIT_ANGLE, 32'h8000_0000);
        write_reg(CFG_DLY_WHOLE, 255);
        it.restart = 1;
        it.noise = 16'sd0;
        add_pending(it);
        it.restart = 0;
        repeat (4) add_pending(it);
        wait_drained();
        write_reg(CFG_STEP_DT, 0);
        write_reg(CFG_NOISE, 0);
        write_reg(CFG_DLY_WHOLE, 2);
        write_reg(CFG_DLY_FRAC, 32'h8000);
        it.restart = 1;
        add_pending(it);
        it.restart = 0;
        repeat (4) add_pending(it);
        wait_drained();

        for (int ph = 0; ph < 16; ph++) begin
            w = (ph % 4 == 3) ? 8'($urandom_range(250, 255))
                              : 8'($urandom_range(0, 12));
            write_reg(CFG_GAIN_K, 32'(pick16(16'h8000, 16'h7FFF)));
            write_reg(CFG_STEP_DT, 32'(pick16(16'h0000, 16'hFFFF)));
            write_reg(CFG_NOISE, $urandom_range(0, 1) ? 32'($urandom_range(0, 4000))
                                                      : 32'(pick16(16'h0000, 16'hFFFF)));
            write_reg(CFG_DLY_WHOLE, 32'(w));
            write_reg(CFG_DLY_FRAC, 32'(pick16(16'h0000, 16'hFFFF)));
            write_reg(CFG_INIT_ANGLE, $urandom);
            send_calm = (ph % 4 == 1);
            recv_calm = (ph % 4 == 2);
            it.restart = 1;
            it.noise = 16'($urandom);
            add_pending(it);
            queue_random((ph % 4 == 3) ? 250 : 50);
            if (ph == 5) hold_req = 1'b1;
            wait_drained();
        end

        write_reg(CFG_GAIN_K, 328);
        write_reg(CFG_STEP_DT, 6554);
        write_reg(CFG_NOISE, 2072);
        write_reg(CFG_DLY_WHOLE, 200);
        write_reg(CFG_DLY_FRAC, 0);
        write_reg(CFG_INIT_ANGLE, 421658414);
        queue_random(40);
        wait_drained();

        if (error_count == 0) begin
            $display("delay_sde_heun_step_tb OK");
        end else begin
            $display("delay_sde_heun_step_tb NOT OK");
        end
        $finish;
    end

endmodule
